// ===== sv/mfv_pkg.sv =====
// Package for the muscle force-velocity unit: word widths, Q16 curve constants
// and configuration register indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mfv_pkg;

    // Stream word widths (fields padded up to whole bytes).
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 88;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_VELOCITY    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ISOMETRIC_FORCE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CURVE_SHAPE     = 2'd2;

    // Register reset values.
    localparam logic [30:0] MAX_VELOCITY_RST    = 31'd65536;
    localparam logic [31:0] ISOMETRIC_FORCE_RST = 32'd0;
    localparam logic [15:0] CURVE_SHAPE_RST     = 16'd1024;

    // Quotient bits of the curve and relative-velocity dividers and of the sigma divider.
    localparam int DIVF_Q = 17;
    localparam int DIVS_Q = 21;

    // Curve constants in Q16, rounded to nearest.
    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [16:0] K_1P8   = 17'd117965;
    localparam logic [15:0] K_0P8   = 16'd52429;
    localparam logic [18:0] K_7P56  = 19'd495452;
    localparam logic [15:0] K_0P506 = 16'd33161;
    localparam logic [17:0] K_2P46  = 18'd161219;
    localparam logic [16:0] K_1P13  = 17'd74056;
    localparam logic [19:0] K_12P8  = 20'd838861;
    localparam logic [16:0] K_1P64  = 17'd107479;

    // Constant terms of the sigma numerator and denominator in Q32.
    localparam logic signed [39:0] NUM_BASE = 40'sd231931904;
    localparam logic signed [39:0] DEN_BASE = 40'sd4294967296;

    // Upper limit of sigma.
    localparam logic [20:0] SIGMA_CAP = 21'h100000;

endpackage

`default_nettype wire

// ===== sv/muscle_force_velocity_unit.sv =====
// Muscle force-velocity unit: takes one word per clock while the result stream
// is not stalled. The pipeline runs through the 17-step restoring divider for
// the curve quotient and relative velocity, followed by the 21-step divider for
// sigma. Depends on mfv_pkg and mfv_div.
`timescale 1ns / 1ps
`default_nettype none

module muscle_force_velocity_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Configuration write port.
    input  wire logic                             cfg_we,
    input  wire logic [mfv_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [mfv_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Input stream.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // s_tdata: activation [17:0], strap_velocity [49:18], zero pad [55:50].
    input  wire logic [mfv_pkg::S_TDATA_W-1:0]    s_tdata,
    // Result stream.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // m_tdata: tension [32:0], metabolic_power [80:33], zero pad [87:81].
    output logic [mfv_pkg::M_TDATA_W-1:0]         m_tdata
);

    localparam int LAT = 2 + mfv_pkg::DIVF_Q + 4 + mfv_pkg::DIVS_Q + 2;
    localparam int V_DIVF_OUT = 1 + mfv_pkg::DIVF_Q;

    // Configuration registers.
    logic [30:0] max_velocity_reg;
    logic [31:0] isometric_force_reg;
    logic [15:0] curve_shape_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_velocity_reg    <= mfv_pkg::MAX_VELOCITY_RST;
            isometric_force_reg <= mfv_pkg::ISOMETRIC_FORCE_RST;
            curve_shape_reg     <= mfv_pkg::CURVE_SHAPE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                mfv_pkg::REG_MAX_VELOCITY:    max_velocity_reg    <= cfg_wdata[30:0];
                mfv_pkg::REG_ISOMETRIC_FORCE: isometric_force_reg <= cfg_wdata;
                mfv_pkg::REG_CURVE_SHAPE:     curve_shape_reg     <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Zero velocity limit and zero curvature read as one.
    logic [30:0] vmax;
    logic [15:0] kc;
    assign vmax = (max_velocity_reg == '0) ? 31'd1 : max_velocity_reg;
    assign kc   = (curve_shape_reg == '0) ? 16'd1 : curve_shape_reg;

    // Products of configuration values, refreshed every cycle.
    logic [46:0] kv_reg;
    logic [50:0] pf_reg;
    logic [62:0] fv_prod;
    assign fv_prod = 63'(isometric_force_reg) * 63'(vmax);

    always_ff @(posedge aclk) begin
        kv_reg <= 47'(vmax) * 47'(kc);
        pf_reg <= fv_prod[62:12];
    end

    // The whole pipeline moves when the output register is empty or being taken.
    logic adv;
    logic [LAT-1:0] vld_reg;
    assign adv      = m_tready || !vld_reg[LAT-1];
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // Stage 1: clamp activation and velocity; lengthening is positive.
    logic signed [17:0] act;
    logic [31:0] sv;
    logic [31:0] umag;
    logic        sv_pos;
    logic [16:0] a1_next;
    logic [30:0] mag1_next;
    logic [16:0] a1_reg;
    logic        neg1_reg;
    logic [30:0] mag1_reg;

    assign act    = s_tdata[17:0];
    assign sv     = s_tdata[49:18];
    assign sv_pos = !sv[31] && (sv[30:0] != '0);
    assign umag   = sv_pos ? sv : (32'd0 - sv);

    always_comb begin
        if (act[17]) begin
            a1_next = '0;
        end else if (act[16:0] > mfv_pkg::ONE_Q16) begin
            a1_next = mfv_pkg::ONE_Q16;
        end else begin
            a1_next = act[16:0];
        end
        mag1_next = (umag > {1'b0, vmax}) ? vmax : umag[30:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a1_reg   <= a1_next;
            neg1_reg <= sv_pos;
            mag1_reg <= mag1_next;
        end
    end

    // Stage 2: numerator and denominator of the curve quotient.
    logic [49:0] lng_prod;
    logic [46:0] nf2_next;
    logic [47:0] df2_next;
    logic [46:0] nf2_reg;
    logic [47:0] df2_reg;
    logic [30:0] mag2_reg;
    logic [16:0] a2_reg;
    logic        neg2_reg;

    assign lng_prod = 50'(mfv_pkg::K_7P56) * 50'(mag1_reg);
    assign nf2_next = 47'(vmax - mag1_reg) * 47'(kc);
    assign df2_next = 48'(kv_reg) + (neg1_reg ? 48'(lng_prod[49:8]) : 48'({mag1_reg, 8'b0}));

    always_ff @(posedge aclk) begin
        if (adv) begin
            nf2_reg  <= nf2_next;
            df2_reg  <= df2_next;
            mag2_reg <= mag1_reg;
            a2_reg   <= a1_reg;
            neg2_reg <= neg1_reg;
        end
    end

    // Curve quotient and relative velocity, both at most one in Q16.
    logic [16:0] qf;
    logic [16:0] rel;

    mfv_div #(.DW(48), .QW(mfv_pkg::DIVF_Q)) u_div_force (
        .aclk   (aclk),
        .en     (adv),
        .rem_i  ({2'b0, nf2_reg[46:1]}),
        .bits_i ({nf2_reg[0], 16'b0}),
        .div_i  (df2_reg),
        .quo_o  (qf)
    );

    mfv_div #(.DW(31), .QW(mfv_pkg::DIVF_Q)) u_div_rel (
        .aclk   (aclk),
        .en     (adv),
        .rem_i  ({1'b0, mag2_reg[30:1]}),
        .bits_i ({mag2_reg[0], 16'b0}),
        .div_i  (vmax),
        .quo_o  (rel)
    );

    // Activation and direction travel beside the dividers.
    logic [16:0] dla_reg [mfv_pkg::DIVF_Q];
    logic        dln_reg [mfv_pkg::DIVF_Q];

    always_ff @(posedge aclk) begin
        if (adv) begin
            dla_reg[0] <= a2_reg;
            dln_reg[0] <= neg2_reg;
            for (int i = 1; i < mfv_pkg::DIVF_Q; i++) begin
                dla_reg[i] <= dla_reg[i-1];
                dln_reg[i] <= dln_reg[i-1];
            end
        end
    end

    // Stage 20: lengthening branch of the curve; square of relative velocity.
    logic [32:0] t_prod;
    logic [33:0] rr_prod;
    logic [16:0] y20_next;
    logic [16:0] y20_reg;
    logic [16:0] rel20_reg;
    logic [16:0] rel2_20_reg;
    logic        neg20_reg;
    logic [16:0] a20_reg;

    assign t_prod   = 33'(mfv_pkg::K_0P8) * 33'(qf);
    assign rr_prod  = 34'(rel) * 34'(rel);
    assign y20_next = dln_reg[mfv_pkg::DIVF_Q-1] ? (mfv_pkg::K_1P8 - t_prod[32:16]) : qf;

    always_ff @(posedge aclk) begin
        if (adv) begin
            y20_reg     <= y20_next;
            rel20_reg   <= rel;
            rel2_20_reg <= rr_prod[32:16];
            neg20_reg   <= dln_reg[mfv_pkg::DIVF_Q-1];
            a20_reg     <= dla_reg[mfv_pkg::DIVF_Q-1];
        end
    end

    // Stage 21: full force, cube of relative velocity, power scale.
    logic [48:0] ff_prod;
    logic [33:0] r3_prod;
    logic [67:0] pa_prod;
    logic [32:0] ff21_reg;
    logic [16:0] rel21_reg;
    logic [16:0] rel2_21_reg;
    logic [16:0] rel3_21_reg;
    logic        neg21_reg;
    logic [16:0] a21_reg;
    logic [50:0] pa21_reg;

    assign ff_prod = 49'(isometric_force_reg) * 49'(y20_reg);
    assign r3_prod = 34'(rel2_20_reg) * 34'(rel20_reg);
    assign pa_prod = 68'(pf_reg) * 68'(a20_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            ff21_reg    <= ff_prod[48:16];
            rel21_reg   <= rel20_reg;
            rel2_21_reg <= rel2_20_reg;
            rel3_21_reg <= r3_prod[32:16];
            neg21_reg   <= neg20_reg;
            a21_reg     <= a20_reg;
            pa21_reg    <= pa_prod[66:16];
        end
    end

    // Stage 22: tension and the terms of sigma.
    logic [49:0] ten_prod;
    logic [32:0] ten22_reg;
    logic [32:0] m1_reg;
    logic [34:0] m2_reg;
    logic [33:0] m3_reg;
    logic [36:0] m4_reg;
    logic [33:0] m5_reg;
    logic        neg22_reg;
    logic [50:0] pa22_reg;

    assign ten_prod = 50'(ff21_reg) * 50'(a21_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            ten22_reg <= ten_prod[49] ? '1 : ten_prod[48:16];
            m1_reg    <= 33'(mfv_pkg::K_0P506) * 33'(rel21_reg);
            m2_reg    <= 35'(mfv_pkg::K_2P46) * 35'(rel2_21_reg);
            m3_reg    <= 34'(mfv_pkg::K_1P13) * 34'(rel21_reg);
            m4_reg    <= 37'(mfv_pkg::K_12P8) * 37'(rel2_21_reg);
            m5_reg    <= 34'(mfv_pkg::K_1P64) * 34'(rel3_21_reg);
            neg22_reg <= neg21_reg;
            pa22_reg  <= pa21_reg;
        end
    end

    // Stage 23: sigma numerator and denominator with their guards.
    logic signed [39:0] s1;
    logic signed [39:0] s2;
    logic signed [39:0] s3;
    logic signed [39:0] s4;
    logic signed [39:0] s5;
    logic signed [39:0] num;
    logic signed [39:0] den;
    logic [33:0] num23_next;
    logic [36:0] den23_next;
    logic [33:0] num23_reg;
    logic [36:0] den23_reg;
    logic        ovf23_reg;
    logic [32:0] ten23_reg;
    logic [50:0] pa23_reg;

    always_comb begin
        s1  = neg22_reg ? -$signed(40'(m1_reg)) : $signed(40'(m1_reg));
        s2  = $signed(40'(m2_reg));
        s3  = neg22_reg ? -$signed(40'(m3_reg)) : $signed(40'(m3_reg));
        s4  = $signed(40'(m4_reg));
        s5  = neg22_reg ? -$signed(40'(m5_reg)) : $signed(40'(m5_reg));
        num = mfv_pkg::NUM_BASE + s1 + s2;
        den = mfv_pkg::DEN_BASE - s3 + s4 - s5;
        num23_next = num[39] ? '0 : num[33:0];
        den23_next = (den < 40'sd1) ? 37'd1 : den[36:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            num23_reg <= num23_next;
            den23_reg <= den23_next;
            ovf23_reg <= 37'(num23_next[33:5]) >= den23_next;
            ten23_reg <= ten22_reg;
            pa23_reg  <= pa22_reg;
        end
    end

    // Sigma quotient.
    logic [20:0] qs;

    mfv_div #(.DW(37), .QW(mfv_pkg::DIVS_Q)) u_div_sigma (
        .aclk   (aclk),
        .en     (adv),
        .rem_i  ({8'b0, num23_reg[33:5]}),
        .bits_i ({num23_reg[4:0], 16'b0}),
        .div_i  (den23_reg),
        .quo_o  (qs)
    );

    logic [32:0] dlt_reg [mfv_pkg::DIVS_Q];
    logic [50:0] dlp_reg [mfv_pkg::DIVS_Q];
    logic        dlo_reg [mfv_pkg::DIVS_Q];

    always_ff @(posedge aclk) begin
        if (adv) begin
            dlt_reg[0] <= ten23_reg;
            dlp_reg[0] <= pa23_reg;
            dlo_reg[0] <= ovf23_reg;
            for (int i = 1; i < mfv_pkg::DIVS_Q; i++) begin
                dlt_reg[i] <= dlt_reg[i-1];
                dlp_reg[i] <= dlp_reg[i-1];
                dlo_reg[i] <= dlo_reg[i-1];
            end
        end
    end

    // Stage 45: capped sigma times the power scale.
    logic [20:0] sg;
    logic [71:0] pw_prod;
    logic [55:0] pw45_reg;
    logic [32:0] ten45_reg;

    assign sg = (dlo_reg[mfv_pkg::DIVS_Q-1] || (qs > mfv_pkg::SIGMA_CAP))
              ? mfv_pkg::SIGMA_CAP : qs;
    assign pw_prod = 72'(dlp_reg[mfv_pkg::DIVS_Q-1]) * 72'(sg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            pw45_reg  <= pw_prod[71:16];
            ten45_reg <= dlt_reg[mfv_pkg::DIVS_Q-1];
        end
    end

    // Output register: power saturates to 48 bits.
    logic [mfv_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [47:0] power_sat;

    assign power_sat = (pw45_reg[55:48] != '0) ? '1 : pw45_reg[47:0];

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= {7'b0, power_sat, ten45_reg};
        end
    end

    assign m_tdata = m_tdata_reg;

    // A stalled pipeline keeps every valid bit in place.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> vld_reg == '0)
        else $error("pipeline not empty after reset");

    // The first dividers never give more than one in Q16 for a live word.
    a_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[V_DIVF_OUT] |-> (qf <= mfv_pkg::ONE_Q16) && (rel <= mfv_pkg::ONE_Q16))
        else $error("curve quotient or relative velocity above one");

endmodule

`default_nettype wire

// ===== sv/mfv_div.sv =====
// Pipelined restoring divider of the muscle force-velocity unit, one quotient
// bit per register stage. Standalone; used three times by the top level.
`timescale 1ns / 1ps
`default_nettype none

module mfv_div #(
    parameter int DW = 48,
    parameter int QW = 17
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [DW-1:0] rem_i,
    input  wire logic [QW-1:0] bits_i,
    input  wire logic [DW-1:0] div_i,
    output logic      [QW-1:0] quo_o
);

    // The caller seeds the partial remainder below the divisor; the low
    // dividend bits are shifted in most significant first.
    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] bits_reg [QW];
    logic [DW-1:0] dv_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    for (genvar g = 0; g < QW; g++) begin : g_step
        logic [DW-1:0] rem_in;
        logic [DW-1:0] dv_in;
        logic [QW-1:0] bits_in;
        logic [QW-1:0] quo_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          take;
        logic [DW-1:0] rem_next;

        if (g == 0) begin : g_first
            assign rem_in  = rem_i;
            assign dv_in   = div_i;
            assign bits_in = bits_i;
            assign quo_in  = '0;
        end else begin : g_rest
            assign rem_in  = rem_reg[g-1];
            assign dv_in   = dv_reg[g-1];
            assign bits_in = bits_reg[g-1];
            assign quo_in  = quo_reg[g-1];
        end

        // Trial subtraction of the divisor from the shifted remainder.
        assign trial    = {rem_in, bits_in[QW-1]};
        assign diff     = trial - {1'b0, dv_in};
        assign take     = trial >= {1'b0, dv_in};
        assign rem_next = take ? diff[DW-1:0] : trial[DW-1:0];

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g]  <= rem_next;
                bits_reg[g] <= {bits_in[QW-2:0], 1'b0};
                dv_reg[g]   <= dv_in;
                quo_reg[g]  <= {quo_in[QW-2:0], take};
            end
        end
    end

    assign quo_o = quo_reg[QW-1];

endmodule

`default_nettype wire
